FILE: hdl/dnsqle_pkg.sv
// shared constants, types and helpers for the dns name label encoder
package dnsqle_pkg;

   localparam int unsigned LABEL_MAX   = 63;
   localparam int unsigned FILL_W      = 6;
   localparam int unsigned CH_W        = 8;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned DOT_W       = 2;
   localparam int unsigned ERR_W       = 3;
   localparam int unsigned STATE_W     = 2;

   localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 8'd128;
   localparam logic [DOT_W-1:0]   MIN_DOT_RESET = 2'd2;

   localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;

   // configuration register indexes
   localparam logic CSR_MAX_NAME_LENGTH = 1'b0;
   localparam logic CSR_MIN_DOT_COUNT   = 1'b1;

   // name error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG = 3'd1;
   localparam logic [ERR_W-1:0] ERR_FEW_DOTS = 3'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_CHAR = 3'd3;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic take_char;
      logic send_len;
      logic send_byte;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic close_label;
      logic fill_zero;
      logic last_byte;
      logic out_free;
   } status_type;

   function automatic logic char_ok(input logic [CH_W-1:0] c);
      logic ok;
      ok = ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_HYPHEN);
      return ok;
   endfunction

endpackage

FILE: hdl/dnsqle_ctrl.sv
// controller state machine for the dns name label encoder
module dnsqle_ctrl
   import dnsqle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [STATE_W-1:0] S_IDLE = 2'd0;
   localparam logic [STATE_W-1:0] S_LEN  = 2'd1;
   localparam logic [STATE_W-1:0] S_SEND = 2'd2;
   localparam logic [STATE_W-1:0] S_WAIT = 2'd3;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.take_char = 1'b0;
      cmd.send_len  = 1'b0;
      cmd.send_byte = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_char = 1'b1;
               if (status.close_label) state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (status.out_free) begin
               cmd.send_len = 1'b1;
               state_in     = status.fill_zero ? S_IDLE : S_SEND;
            end
         end
         S_SEND: begin
            if (status.out_free) begin
               cmd.send_byte = 1'b1;
               state_in      = status.last_byte ? S_IDLE : S_WAIT;
            end
         end
         S_WAIT: begin
            // store read of the next byte lands this cycle
            state_in = S_SEND;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_close_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_char && status.close_label) |=> (state_ff == S_LEN))
      else $error("closing character did not start label readout");

   a_empty_label_one_byte: assert property (@(posedge clock) disable iff (reset)
      (cmd.send_len && status.fill_zero) |=> (state_ff == S_IDLE))
      else $error("empty label sent more than its length byte");

   a_send_progress: assert property (@(posedge clock) disable iff (reset)
      (cmd.send_byte && !status.last_byte) |=> (state_ff == S_WAIT))
      else $error("label readout skipped the read wait");

endmodule

FILE: hdl/dnsqle_dpath.sv
// label store, name checks, configuration and output register
module dnsqle_dpath
   import dnsqle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [CH_W-1:0]     req_ch,
   input  logic                req_is_final_char,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [COUNT_W-1:0]  csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CH_W-1:0]     rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_name_end,
   output logic [ERR_W-1:0]    rsp_name_error
);

   logic [CH_W-1:0] store_mem [LABEL_MAX];

   logic [FILL_W-1:0]  label_fill_ff,   label_fill_in;
   logic [COUNT_W-1:0] name_count_ff,   name_count_in;
   logic [DOT_W-1:0]   dot_count_ff,    dot_count_in;
   logic               bad_char_ff,     bad_char_in;
   logic               overflow_ff,     overflow_in;
   logic               fin_ff,          fin_in;
   logic [ERR_W-1:0]   err_ff,          err_in;
   logic [FILL_W-1:0]  emit_len_ff,     emit_len_in;
   logic [FILL_W-1:0]  rd_idx_ff,       rd_idx_in;
   logic [CH_W-1:0]    rd_data_ff;
   logic [COUNT_W-1:0] max_len_ff,      max_len_in;
   logic [DOT_W-1:0]   min_dot_ff,      min_dot_in;
   logic               out_valid_ff,    out_valid_in;
   logic [CH_W-1:0]    out_byte_ff,     out_byte_in;
   logic               out_last_ff,     out_last_in;
   logic               out_end_ff,      out_end_in;
   logic [ERR_W-1:0]   out_err_ff,      out_err_in;

   logic               is_dot;
   logic               store_wr;
   logic [ERR_W-1:0]   verdict;
   logic               len_last;

   assign is_dot   = (req_ch == CH_DOT);
   assign store_wr = cmd.take_char && !is_dot &&
                     (label_fill_ff < FILL_W'(LABEL_MAX));

   always_comb begin
      if (name_count_ff > max_len_ff) begin
         verdict = ERR_TOO_LONG;
      end else if (dot_count_ff < min_dot_ff) begin
         verdict = ERR_FEW_DOTS;
      end else if (bad_char_ff) begin
         verdict = ERR_BAD_CHAR;
      end else if (overflow_ff) begin
         verdict = ERR_OVERFLOW;
      end else begin
         verdict = ERR_NONE;
      end
   end

   assign len_last = (label_fill_ff == '0);

   always_comb begin
      label_fill_in = label_fill_ff;
      name_count_in = name_count_ff;
      dot_count_in  = dot_count_ff;
      bad_char_in   = bad_char_ff;
      overflow_in   = overflow_ff;
      fin_in        = fin_ff;
      err_in        = err_ff;
      emit_len_in   = emit_len_ff;
      rd_idx_in     = rd_idx_ff;
      max_len_in    = max_len_ff;
      min_dot_in    = min_dot_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_end_in    = out_end_ff;
      out_err_in    = out_err_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_NAME_LENGTH: max_len_in = csr_wdata;
            CSR_MIN_DOT_COUNT:   min_dot_in = csr_wdata[DOT_W-1:0];
            default:             max_len_in = max_len_ff;
         endcase
      end

      if (cmd.take_char) begin
         fin_in    = req_is_final_char;
         rd_idx_in = '0;
         if (name_count_ff != '1) name_count_in = name_count_ff + COUNT_W'(1);
         if (is_dot) begin
            if (dot_count_ff != '1) dot_count_in = dot_count_ff + DOT_W'(1);
         end else begin
            if (!char_ok(req_ch)) bad_char_in = 1'b1;
            if (store_wr) label_fill_in = label_fill_ff + FILL_W'(1);
            else          overflow_in   = 1'b1;
         end
      end

      if (cmd.send_len) begin
         emit_len_in   = label_fill_ff;
         label_fill_in = '0;
         err_in        = verdict;
         out_valid_in  = 1'b1;
         out_byte_in   = CH_W'(label_fill_ff);
         out_last_in   = len_last;
         out_end_in    = len_last && fin_ff;
         out_err_in    = (len_last && fin_ff) ? verdict : ERR_NONE;
         if (fin_ff) begin
            name_count_in = '0;
            dot_count_in  = '0;
            bad_char_in   = 1'b0;
            overflow_in   = 1'b0;
         end
      end

      if (cmd.send_byte) begin
         rd_idx_in    = rd_idx_ff + FILL_W'(1);
         out_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         out_last_in  = status.last_byte;
         out_end_in   = status.last_byte && fin_ff;
         out_err_in   = (status.last_byte && fin_ff) ? err_ff : ERR_NONE;
      end
   end

   // label store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (store_wr) store_mem[label_fill_ff] <= req_ch;
      rd_data_ff <= store_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_fill_ff <= '0;
         name_count_ff <= '0;
         dot_count_ff  <= '0;
         bad_char_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         fin_ff        <= 1'b0;
         max_len_ff    <= MAX_LEN_RESET;
         min_dot_ff    <= MIN_DOT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         label_fill_ff <= label_fill_in;
         name_count_ff <= name_count_in;
         dot_count_ff  <= dot_count_in;
         bad_char_ff   <= bad_char_in;
         overflow_ff   <= overflow_in;
         fin_ff        <= fin_in;
         max_len_ff    <= max_len_in;
         min_dot_ff    <= min_dot_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      emit_len_ff <= emit_len_in;
      rd_idx_ff   <= rd_idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
      out_err_ff  <= out_err_in;
   end

   assign status.close_label = is_dot || req_is_final_char;
   assign status.fill_zero   = len_last;
   assign status.last_byte   = ((rd_idx_ff + FILL_W'(1)) == emit_len_ff);
   assign status.out_free    = !out_valid_ff || !rsp_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_name_end   = out_end_ff;
   assign rsp_name_error = out_err_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_end_ff) |-> out_last_ff)
      else $error("name end on a result that is not the last of its run");

   a_err_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_end_ff) |-> (out_err_ff == ERR_NONE))
      else $error("name error on a result that does not close the name");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.take_char |=> (label_fill_ff <= FILL_W'(LABEL_MAX)))
      else $error("label fill beyond the label limit");

endmodule

FILE: hdl/dns_qname_label_encoder_unit.sv
// top level of the dns name label encoder
// Takes a dotted hostname one character per transaction and returns it in DNS
// label form: per label a length byte, then the label's characters. A dot or the
// character marked final closes the open label; a final dot closes the name
// without an empty label after it. Length, dot count and character set are
// checked as the name goes by, and the error code (0 ok, 1 too long, 2 too few
// dots, 3 bad character, 4 label longer than 63) rides on the result that
// closes the name with rsp_name_end set. A character that does not close a
// label is taken without a stall. A closing character is taken in, then its
// length byte is sent, then each label character with a store read wait
// after every one but the last (only the length byte for an empty label),
// before the next character is taken; the pace is set by the label store,
// whose read data is registered. An output stall holds the readout; a stall
// that falls on a store read wait costs nothing. No clearing pass is needed
// after reset.
// Configuration writes are taken at any time (csr_ready is always high) but are
// meant for idle periods; the length and dot limits are sampled when a name
// closes.
module dns_qname_label_encoder_unit
   import dnsqle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // character transactions
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CH_W-1:0]    req_ch,
   input  logic               req_is_final_char,
   // encoded byte transactions
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CH_W-1:0]    rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_name_end,
   output logic [ERR_W-1:0]   rsp_name_error,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [COUNT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // register port never back-pressures
   assign csr_ready = 1'b1;

   // sequencer: take character, send length, then read out the label
   dnsqle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, counters, checks and the output register
   dnsqle_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_ch            (req_ch),
      .req_is_final_char (req_is_final_char),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_name_end      (rsp_name_end),
      .rsp_name_error    (rsp_name_error)
   );

endmodule

FILE: tb/dns_qname_label_encoder_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the dns name label encoder unit
module dns_qname_label_encoder_unit_tb;
   import dnsqle_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_500_000;
   // idle wait after the last owed byte has come out
   localparam int unsigned SETTLE_CYCLES = 140;
   localparam int unsigned RANDOM_CHARS  = 40;
   localparam int unsigned REPORT_MAX    = 10;

   // one encoded byte as it leaves the block
   typedef struct packed {
      logic [CH_W-1:0]  out_byte;
      logic             run_last;
      logic             name_end;
      logic [ERR_W-1:0] name_error;
   } enc_byte_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CH_W-1:0]    req_ch = '0;
   logic               req_is_final_char = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CH_W-1:0]    rsp_out_byte;
   logic               rsp_run_last;
   logic               rsp_name_end;
   logic [ERR_W-1:0]   rsp_name_error;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = CSR_MAX_NAME_LENGTH;
   logic [COUNT_W-1:0] csr_wdata = '0;

   dns_qname_label_encoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .req_is_final_char (req_is_final_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_name_end      (rsp_name_end),
      .rsp_name_error    (rsp_name_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // encoder state as the testbench sees it
   // ---------------------------------------------------------------------
   logic [CH_W-1:0]    label_buf [LABEL_MAX];
   int                 label_len     = 0;
   logic [COUNT_W-1:0] name_chars    = '0;
   logic [DOT_W-1:0]   name_dots     = '0;
   logic               bad_seen      = 1'b0;
   logic               overflow_seen = 1'b0;
   logic [COUNT_W-1:0] cfg_max_len   = MAX_LEN_RESET;
   logic [DOT_W-1:0]   cfg_min_dots  = MIN_DOT_RESET;

   // encoded bytes still owed by the block, oldest first
   enc_byte_type bytes_due [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned chars_sent     = 0;
   int unsigned burst_left     = 0;
   logic [8:0]  stall_phase    = '0;

   function automatic logic is_host_char(input logic [CH_W-1:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || (c == CH_HYPHEN);
   endfunction

   // lowest error code wins when several apply
   function automatic logic [ERR_W-1:0] name_verdict;
      if (name_chars > cfg_max_len) return ERR_TOO_LONG;
      if (name_dots < cfg_min_dots) return ERR_FEW_DOTS;
      if (bad_seen) return ERR_BAD_CHAR;
      if (overflow_seen) return ERR_OVERFLOW;
      return ERR_NONE;
   endfunction

   // update the name state with one accepted character and queue what it emits
   function automatic void encode_char(input logic [CH_W-1:0] c, input logic fin);
      enc_byte_type e;
      int           i;
      if (name_chars != 8'hFF) name_chars = name_chars + 1'b1;
      if (c == CH_DOT) begin
         if (name_dots != 2'd3) name_dots = name_dots + 1'b1;
      end else begin
         if (!is_host_char(c)) bad_seen = 1'b1;
         // a full label drops the character and remembers the overflow
         if (label_len < LABEL_MAX) begin
            label_buf[label_len] = c;
            label_len++;
         end else begin
            overflow_seen = 1'b1;
         end
      end
      // a dot or the final character flushes the open label: length, then bytes
      if (fin || c == CH_DOT) begin
         for (i = 0; i <= label_len; i++) begin
            e.out_byte   = (i == 0) ? 8'(label_len) : label_buf[i-1];
            e.run_last   = (i == label_len);
            e.name_end   = fin && (i == label_len);
            e.name_error = e.name_end ? name_verdict() : ERR_NONE;
            bytes_due    = {bytes_due, e};
         end
         label_len = 0;
      end
      if (fin) begin
         name_chars    = '0;
         name_dots     = '0;
         bad_seen      = 1'b0;
         overflow_seen = 1'b0;
      end
   endfunction

   function automatic logic [CH_W-1:0] pick_host_char;
      int unsigned r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return CH_HYPHEN;
   endfunction

   // ---------------------------------------------------------------------
   // output side: stall pattern and byte checker
   // ---------------------------------------------------------------------

   // the stall pattern moves through four modes in turn
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_mode_type'(stall_phase[8:7]))
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase[2:0] < 3'd3);
         default:        rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin : check_bytes
      enc_byte_type exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bytes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected byte %02h last %b end %b err %0d", $time,
                        rsp_out_byte, rsp_run_last, rsp_name_end, rsp_name_error);
         end else begin
            exp_b = bytes_due.pop_front();
            if (rsp_out_byte !== exp_b.out_byte || rsp_run_last !== exp_b.run_last ||
                rsp_name_end !== exp_b.name_end || rsp_name_error !== exp_b.name_error)
            begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"%0t: byte mismatch expected %02h/%b/%b/%0d",
                            " got %02h/%b/%b/%0d (byte/last/end/err)"}, $time,
                           exp_b.out_byte, exp_b.run_last, exp_b.name_end,
                           exp_b.name_error, rsp_out_byte, rsp_run_last,
                           rsp_name_end, rsp_name_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------

   // one character transaction; the sender runs in bursts with random gaps
   task automatic send_char(input logic [CH_W-1:0] c, input logic fin);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         // one burst in four, at random, follows straight on with no gap
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid         = 1'b1;
      req_ch            = c;
      req_is_final_char = fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encode_char(c, fin);
      chars_sent++;
   endtask

   task automatic send_name(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // drop valid and let every owed byte come out, then let the block settle
   task automatic wait_idle;
      @(negedge clock);
      req_valid = 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MAX_NAME_LENGTH) cfg_max_len = val;
      else cfg_min_dots = val[DOT_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_limits(input logic [COUNT_W-1:0] max_len,
                             input logic [COUNT_W-1:0] min_dots_raw);
      wait_idle();
      write_reg(CSR_MAX_NAME_LENGTH, max_len);
      write_reg(CSR_MIN_DOT_COUNT, min_dots_raw);
   endtask

   task automatic send_label(input int len, input logic fin_on_last);
      int j;
      for (j = 0; j < len; j++) send_char(pick_host_char(), fin_on_last && j == len - 1);
   endtask

   // mostly well-formed names with random content, some pure noise
   task automatic send_random_name;
      int   labels, len, i, j;
      logic trail_dot, last_label;
      logic [CH_W-1:0] c;
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
      end else begin
         labels    = $urandom_range(1, 5);
         trail_dot = ($urandom_range(0, 5) == 0);
         for (i = 0; i < labels; i++) begin
            // now and then a label of 60 to 66 characters, which may overflow
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 10);
            last_label = (i == labels - 1);
            if (last_label && !trail_dot && len == 0) len = 1;
            for (j = 0; j < len; j++) begin
               c = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) : pick_host_char();
               send_char(c, last_label && !trail_dot && j == len - 1);
            end
            if (!last_label || trail_dot) send_char(CH_DOT, last_label);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset values of the limits, mixed case, digits and a hyphen
   task automatic test_default_settings;
      send_name("a0.Z-.z9");
   endtask

   // empty labels: two dots in a row, then a lone final dot
   task automatic test_empty_labels;
      send_name("..");
      send_name(".");
   endtask

   // characters just outside each allowed range, plus both byte extremes
   task automatic test_bad_chars;
      logic [CH_W-1:0] odd [11];
      int i;
      odd = '{8'h00, 8'h2F, 8'hFF, CH_DOT, 8'h7B, 8'h40, CH_DOT,
              8'h60, 8'h5B, 8'h2C, 8'h3A};
      for (i = 0; i < 11; i++) send_char(odd[i], i == 10);
   endtask

   // zero length limit, dot limit written with upper bits set, loosest limits
   task automatic test_register_extremes;
      set_limits(8'd0, 8'd0);
      send_name("q");
      set_limits(8'd255, 8'hFF);
      send_name("a.b");
      set_limits(8'd255, 8'd0);
      send_name("q");
   endtask

   // a 256 character name: the first label runs past the store depth, the next
   // two fill it exactly, and the length count and the dot count both saturate
   task automatic test_count_saturation;
      set_limits(8'd255, 8'd3);
      send_label(66, 1'b0);
      send_char(CH_DOT, 1'b0);
      send_label(LABEL_MAX, 1'b0);
      send_char(CH_DOT, 1'b0);
      send_label(LABEL_MAX, 1'b0);
      send_char(CH_DOT, 1'b0);
      send_label(58, 1'b0);
      send_char(CH_DOT, 1'b0);
      send_name("ab");
   endtask

   // random names under a run of limit settings, the extremes first
   task automatic test_random_names;
      logic [COUNT_W-1:0] max_set [6];
      logic [COUNT_W-1:0] dot_set [6];
      int unsigned start, phase;
      max_set = '{8'd128, 8'd1, 8'd255, 8'd12, 8'd0, 8'd40};
      dot_set = '{8'd2, 8'd0, 8'd3, 8'd1, 8'd0, 8'd2};
      start = chars_sent;
      phase = 0;
      while (chars_sent - start < RANDOM_CHARS) begin
         if (phase < 6) set_limits(max_set[phase], dot_set[phase]);
         else set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         phase++;
         repeat ($urandom_range(2, 6)) send_random_name();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_settings();
      test_empty_labels();
      test_bad_chars();
      test_register_extremes();
      test_count_saturation();
      test_random_names();
      wait_idle();
      if (mismatch_count == 0 && bytes_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
